### design/bsc_pkg.sv
// shared types, state codes and helpers for the barometric compensation block
`default_nettype none
package bsc_pkg;

    localparam int unsigned CalW    = 48;
    localparam int unsigned RawW    = 20;
    localparam int unsigned CfgIdxW = 8;

    localparam logic [CfgIdxW-1:0] CFG_CAL_TEMP    = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_CAL_PRESS_A = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_CAL_PRESS_B = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_CAL_PRESS_C = 8'd3;

    localparam logic [63:0] FineOffset = 64'd128000;
    localparam logic [63:0] FullScale  = 64'd1048576;
    localparam logic [63:0] PressScale = 64'd3125;
    localparam logic [63:0] GainBias   = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic            func;
        logic [RawW-1:0] raw_sample;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [23:0] temperature;
        logic [31:0]        pressure;
        logic               div_zero;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_A,
        S_T_B,
        S_T_C,
        S_T_OUT,
        S_P_SQ,
        S_P_A,
        S_P_B,
        S_P_D,
        S_P_E,
        S_P_F,
        S_P_CHK,
        S_P_N,
        S_D_IT,
        S_D_FIN,
        S_P_H,
        S_P_I,
        S_P_J,
        S_P_OUT
    } t_state;

    // sign-extend a 16-bit calibration word
    function automatic logic [63:0] sx16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

endpackage
`default_nettype wire

### design/baro_sensor_compensation_top.sv
// barometric compensation top level: sequencer around one shared multiplier and a divider
`default_nettype none
// Takes raw 20-bit samples tagged temperature (func 0) or pressure (func 1) and
// returns one compensated result per sample. One 32x32 multiplier is reused for
// every product; a 64-bit wrapping product is built from three partial products
// plus the final add. A temperature sample needs three products; it also updates
// the stored fine temperature. A pressure sample needs ten products and a
// 64-iteration radix-2 signed divide; when the divisor is zero the divide and
// the last four products are skipped. The block takes one sample at a time:
// o_in_stall is high from acceptance until the result is written into the output
// register. A finished result waits there while the next sample is already
// accepted. Calibration registers are written through the plain write port; the
// user must write them only while idle, as the block itself does not enforce it.
module baro_sensor_compensation_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire bsc_pkg::t_in_item             i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output bsc_pkg::t_out_item                 o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [bsc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [bsc_pkg::CalW-1:0]      i_cfg_data
);

    // calibration registers
    logic [bsc_pkg::CalW-1:0] r_cal_t, r_cal_a, r_cal_b, r_cal_c;

    bsc_pkg::t_state r_state, n_state;

    // sample under work
    logic                     r_func;
    logic [bsc_pkg::RawW-1:0] r_raw;
    logic [31:0]              r_fine;

    // working registers
    logic [63:0] r_sq, r_v1, r_v2, r_t, r_p;

    // shared multiplier
    logic [1:0]  r_ph;
    logic [63:0] r_prod, r_acc;
    logic [63:0] m_a, m_b;
    logic [31:0] m_x, m_y;
    logic [63:0] mres;
    logic        mul_st, mul_done;

    // divider
    logic [63:0] r_q, r_rem, r_d;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [64:0] div_sh;
    logic        div_ge;

    // output register
    bsc_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic               out_free;
    logic               out_load;

    logic        in_xfer;
    logic [63:0] xv;        // fine temperature minus offset
    logic [31:0] ta, tb;    // temperature polynomial terms
    logic [31:0] temp_sum;
    logic [63:0] press_sum;
    logic [31:0] press_out;
    logic [63:0] num_a;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != bsc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // calibration words
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_cal_t[15:0];
    assign t2 = r_cal_t[31:16];
    assign t3 = r_cal_t[47:32];
    assign p1 = r_cal_a[15:0];
    assign p2 = r_cal_a[31:16];
    assign p3 = r_cal_a[47:32];
    assign p4 = r_cal_b[15:0];
    assign p5 = r_cal_b[31:16];
    assign p6 = r_cal_b[47:32];
    assign p7 = r_cal_c[15:0];
    assign p8 = r_cal_c[31:16];
    assign p9 = r_cal_c[47:32];

    assign ta = {15'd0, r_raw[19:3]} - {15'd0, t1, 1'b0};
    assign tb = {16'd0, r_raw[19:4]} - {16'd0, t1};
    assign xv = bsc_pkg::sx32(r_fine) - bsc_pkg::FineOffset;
    assign num_a = ((bsc_pkg::FullScale - {44'd0, r_raw}) << 31) - r_v2;

    // fine * 5 + 128, then arithmetic shift by 8 keeps bits 31:8
    assign temp_sum  = {r_fine[29:0], 2'b00} + r_fine + 32'd128;
    assign press_sum = r_p + r_v1 + r_v2;
    assign press_out = press_sum[39:8] + {{12{p7[15]}}, p7, 4'b0000};

    // states that finish a sample and load the output register
    assign out_load = (r_state == bsc_pkg::S_T_OUT) || (r_state == bsc_pkg::S_P_OUT) ||
                      ((r_state == bsc_pkg::S_P_CHK) && (r_v1 == 64'd0));

    // states that run the multiplier
    always_comb begin
        unique case (r_state)
            bsc_pkg::S_T_A, bsc_pkg::S_T_B, bsc_pkg::S_T_C,
            bsc_pkg::S_P_SQ, bsc_pkg::S_P_A, bsc_pkg::S_P_B, bsc_pkg::S_P_D,
            bsc_pkg::S_P_E, bsc_pkg::S_P_F, bsc_pkg::S_P_N,
            bsc_pkg::S_P_H, bsc_pkg::S_P_I, bsc_pkg::S_P_J: mul_st = 1'b1;
            default:                                         mul_st = 1'b0;
        endcase
    end

    assign mul_done = mul_st && (r_ph == 2'd3);

    // multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            bsc_pkg::S_T_A: begin
                m_a = bsc_pkg::sx32(ta);
                m_b = bsc_pkg::sx16(t2);
            end
            bsc_pkg::S_T_B: begin
                m_a = bsc_pkg::sx32(tb);
                m_b = bsc_pkg::sx32(tb);
            end
            bsc_pkg::S_T_C: begin
                m_a = bsc_pkg::sx32(r_t[31:0]);
                m_b = bsc_pkg::sx16(t3);
            end
            bsc_pkg::S_P_SQ: begin
                m_a = xv;
                m_b = xv;
            end
            bsc_pkg::S_P_A: begin
                m_a = r_sq;
                m_b = bsc_pkg::sx16(p6);
            end
            bsc_pkg::S_P_B: begin
                m_a = xv;
                m_b = bsc_pkg::sx16(p5);
            end
            bsc_pkg::S_P_D: begin
                m_a = r_sq;
                m_b = bsc_pkg::sx16(p3);
            end
            bsc_pkg::S_P_E: begin
                m_a = xv;
                m_b = bsc_pkg::sx16(p2);
            end
            bsc_pkg::S_P_F: begin
                m_a = bsc_pkg::GainBias + r_v1;
                m_b = {48'd0, p1};
            end
            bsc_pkg::S_P_N: begin
                m_a = num_a;
                m_b = bsc_pkg::PressScale;
            end
            bsc_pkg::S_P_H: begin
                m_a = bsc_pkg::sx16(p9);
                m_b = 64'($signed(r_p) >>> 13);
            end
            bsc_pkg::S_P_I: begin
                m_a = r_t;
                m_b = 64'($signed(r_p) >>> 13);
            end
            bsc_pkg::S_P_J: begin
                m_a = bsc_pkg::sx16(p8);
                m_b = r_p;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // partial product pick: lo*lo, hi*lo, lo*hi
    always_comb begin
        case (r_ph)
            2'd0:    begin m_x = m_a[31:0];  m_y = m_b[31:0];  end
            2'd1:    begin m_x = m_a[63:32]; m_y = m_b[31:0];  end
            default: begin m_x = m_a[31:0];  m_y = m_b[63:32]; end
        endcase
    end

    assign mres = r_acc + {r_prod[31:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0;
        end else if (mul_st) begin
            r_ph <= r_ph + 2'd1;
        end else begin
            r_ph <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, m_x} * {32'd0, m_y};
        if (r_ph == 2'd1) begin
            r_acc <= r_prod;
        end else if (r_ph == 2'd2) begin
            r_acc <= mres;
        end
    end

    // divider step: shift in the next dividend bit, subtract when it fits
    assign div_sh = {r_rem, r_q[63]};
    assign div_ge = (div_sh >= {1'b0, r_d});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsc_pkg::S_IDLE:  if (in_xfer) begin
                n_state = i_in.func ? bsc_pkg::S_P_SQ : bsc_pkg::S_T_A;
            end
            bsc_pkg::S_T_A:   if (mul_done) n_state = bsc_pkg::S_T_B;
            bsc_pkg::S_T_B:   if (mul_done) n_state = bsc_pkg::S_T_C;
            bsc_pkg::S_T_C:   if (mul_done) n_state = bsc_pkg::S_T_OUT;
            bsc_pkg::S_T_OUT: if (out_free) n_state = bsc_pkg::S_IDLE;
            bsc_pkg::S_P_SQ:  if (mul_done) n_state = bsc_pkg::S_P_A;
            bsc_pkg::S_P_A:   if (mul_done) n_state = bsc_pkg::S_P_B;
            bsc_pkg::S_P_B:   if (mul_done) n_state = bsc_pkg::S_P_D;
            bsc_pkg::S_P_D:   if (mul_done) n_state = bsc_pkg::S_P_E;
            bsc_pkg::S_P_E:   if (mul_done) n_state = bsc_pkg::S_P_F;
            bsc_pkg::S_P_F:   if (mul_done) n_state = bsc_pkg::S_P_CHK;
            bsc_pkg::S_P_CHK: begin
                if (r_v1 != 64'd0) begin
                    n_state = bsc_pkg::S_P_N;
                end else if (out_free) begin
                    n_state = bsc_pkg::S_IDLE;
                end
            end
            bsc_pkg::S_P_N:   if (mul_done) n_state = bsc_pkg::S_D_IT;
            bsc_pkg::S_D_IT:  if (r_cnt == 6'd63) n_state = bsc_pkg::S_D_FIN;
            bsc_pkg::S_D_FIN: n_state = bsc_pkg::S_P_H;
            bsc_pkg::S_P_H:   if (mul_done) n_state = bsc_pkg::S_P_I;
            bsc_pkg::S_P_I:   if (mul_done) n_state = bsc_pkg::S_P_J;
            bsc_pkg::S_P_J:   if (mul_done) n_state = bsc_pkg::S_P_OUT;
            bsc_pkg::S_P_OUT: if (out_free) n_state = bsc_pkg::S_IDLE;
            default:          n_state = bsc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // calibration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsc_pkg::CFG_CAL_TEMP:    r_cal_t <= i_cfg_data;
                bsc_pkg::CFG_CAL_PRESS_A: r_cal_a <= i_cfg_data;
                bsc_pkg::CFG_CAL_PRESS_B: r_cal_b <= i_cfg_data;
                bsc_pkg::CFG_CAL_PRESS_C: r_cal_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // fine temperature is state kept across samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine <= '0;
        end else if (r_state == bsc_pkg::S_T_C && mul_done) begin
            r_fine <= r_v1[31:0] + 32'($signed(mres[31:0]) >>> 14);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            bsc_pkg::S_IDLE: if (in_xfer) begin
                r_func <= i_in.func;
                r_raw  <= i_in.raw_sample;
            end
            bsc_pkg::S_T_A: if (mul_done) begin
                r_v1 <= {32'd0, 32'($signed(mres[31:0]) >>> 11)};
            end
            bsc_pkg::S_T_B: if (mul_done) begin
                r_t <= {32'd0, 32'($signed(mres[31:0]) >>> 12)};
            end
            bsc_pkg::S_P_SQ: if (mul_done) r_sq <= mres;
            bsc_pkg::S_P_A:  if (mul_done) r_v2 <= mres;
            bsc_pkg::S_P_B: if (mul_done) begin
                r_v2 <= r_v2 + (mres << 17) + (bsc_pkg::sx16(p4) << 35);
            end
            bsc_pkg::S_P_D: if (mul_done) r_v1 <= 64'($signed(mres) >>> 8);
            bsc_pkg::S_P_E: if (mul_done) r_v1 <= r_v1 + (mres << 12);
            bsc_pkg::S_P_F: if (mul_done) r_v1 <= 64'($signed(mres) >>> 33);
            bsc_pkg::S_P_N: if (mul_done) begin
                // operands to magnitudes, sign kept apart
                r_q   <= mres[63] ? (64'd0 - mres) : mres;
                r_d   <= r_v1[63] ? (64'd0 - r_v1) : r_v1;
                r_neg <= mres[63] ^ r_v1[63];
                r_rem <= '0;
                r_cnt <= '0;
            end
            bsc_pkg::S_D_IT: begin
                r_rem <= div_ge ? 64'(div_sh - {1'b0, r_d}) : div_sh[63:0];
                r_q   <= {r_q[62:0], div_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            bsc_pkg::S_D_FIN: r_p <= r_neg ? (64'd0 - r_q) : r_q;
            bsc_pkg::S_P_H: if (mul_done) r_t  <= mres;
            bsc_pkg::S_P_I: if (mul_done) r_v1 <= 64'($signed(mres) >>> 25);
            bsc_pkg::S_P_J: if (mul_done) r_v2 <= 64'($signed(mres) >>> 19);
            default: ;
        endcase
    end

    // output register: load on completion, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (out_free && out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (out_free) begin
                unique case (r_state)
                    bsc_pkg::S_T_OUT: begin
                        r_out.kind        <= r_func;
                        r_out.temperature <= temp_sum[31:8];
                        r_out.pressure    <= '0;
                        r_out.div_zero    <= 1'b0;
                    end
                    bsc_pkg::S_P_CHK: if (r_v1 == 64'd0) begin
                        // zero divisor: pressure forced to zero
                        r_out.kind        <= r_func;
                        r_out.temperature <= '0;
                        r_out.pressure    <= '0;
                        r_out.div_zero    <= 1'b1;
                    end
                    bsc_pkg::S_P_OUT: begin
                        r_out.kind        <= r_func;
                        r_out.temperature <= '0;
                        r_out.pressure    <= press_out;
                        r_out.div_zero    <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### tb/baro_sensor_compensation_top_tb.sv
// self-checking testbench for the barometric compensation block
`timescale 1ns / 100ps
`default_nettype none
module baro_sensor_compensation_top_tb;

    localparam int unsigned MaxCycles = 4_000_000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    bsc_pkg::t_in_item              i_in;
    logic                           o_out_valid;
    logic                           i_out_stall;
    bsc_pkg::t_out_item             o_out;
    logic                           i_cfg_we;
    logic [bsc_pkg::CfgIdxW-1:0]    i_cfg_idx;
    logic [bsc_pkg::CalW-1:0]       i_cfg_data;

    baro_sensor_compensation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // calibration and fine temperature as the predictor sees them
    logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
    logic [31:0] t_fine;

    bsc_pkg::t_in_item   sample_q[$];   // samples waiting for the driver
    bsc_pkg::t_out_item  reading_q[$];  // predicted readings, oldest first
    int         errors = 0;
    int unsigned cycle = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         hold_off = 0;  // long receiver hold-off, in cycles

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // signed 64-bit divide, truncating toward zero, min / -1 wraps
    function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q  = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // compensated reading for one sample; a temperature sample also updates the fine temperature
    function automatic bsc_pkg::t_out_item compensate(input bsc_pkg::t_in_item s);
        bsc_pkg::t_out_item r;
        logic signed [31:0] t1, t2, t3, a, b, v1t, v2t, ft;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, tf, v1, v2, p;
        r = '0;
        r.kind = s.func;
        if (!s.func) begin
            t1 = {16'd0, cal_t[15:0]};
            t2 = {{16{cal_t[31]}}, cal_t[31:16]};
            t3 = {{16{cal_t[47]}}, cal_t[47:32]};
            a   = {15'd0, s.raw_sample[19:3]} - (t1 <<< 1);
            v1t = (a * t2) >>> 11;
            b   = {16'd0, s.raw_sample[19:4]} - t1;
            v2t = (((b * b) >>> 12) * t3) >>> 14;
            ft  = v1t + v2t;
            t_fine = ft;
            ft = (ft * 5 + 128) >>> 8;
            r.temperature = ft[23:0];
        end else begin
            p1 = {48'd0, cal_pa[15:0]};
            p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
            p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
            p4 = {{48{cal_pb[15]}}, cal_pb[15:0]};
            p5 = {{48{cal_pb[31]}}, cal_pb[31:16]};
            p6 = {{48{cal_pb[47]}}, cal_pb[47:32]};
            p7 = {{48{cal_pc[15]}}, cal_pc[15:0]};
            p8 = {{48{cal_pc[31]}}, cal_pc[31:16]};
            p9 = {{48{cal_pc[47]}}, cal_pc[47:32]};
            tf = {{32{t_fine[31]}}, t_fine};
            v1 = tf - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            if (v1 == 0) begin
                r.div_zero = 1'b1;
            end else begin
                p = 64'sd1048576 - {44'd0, s.raw_sample};
                p = div_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
                v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                v2 = (p8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
                r.pressure = p[31:0];
            end
        end
        return r;
    endfunction

    // driver: one transfer per pending sample, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            reading_q.push_back(compensate(i_in));
            void'(sample_q.pop_front());
            if (sample_q.size() > 0 && $urandom_range(0, 3) == 0) begin
                i_in       <= sample_q[0];
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
                in_gap     <= (sample_q.size() > 0) ? $urandom_range(0, 13) : 0;
            end
        end else if (!i_in_valid && sample_q.size() > 0) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else begin
                i_in       <= sample_q[0];
                i_in_valid <= 1'b1;
            end
        end
    end

    // monitor: checks each transfer and draws the receiver's stall
    always @(posedge i_clk) begin
        bsc_pkg::t_out_item exp_r;
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (reading_q.size() == 0) begin
                    $error("unexpected reading %h", o_out);
                    errors++;
                end else begin
                    exp_r = reading_q.pop_front();
                    if (o_out.kind !== exp_r.kind) begin
                        $error("kind exp %0d got %0d", exp_r.kind, o_out.kind);
                        errors++;
                    end
                    if (o_out.temperature !== exp_r.temperature) begin
                        $error("temperature exp %0d got %0d",
                               exp_r.temperature, o_out.temperature);
                        errors++;
                    end
                    if (o_out.pressure !== exp_r.pressure) begin
                        $error("pressure exp %h got %h", exp_r.pressure, o_out.pressure);
                        errors++;
                    end
                    if (o_out.div_zero !== exp_r.div_zero) begin
                        $error("div_zero exp %0d got %0d", exp_r.div_zero, o_out.div_zero);
                        errors++;
                    end
                end
            end
            // long hold-off takes priority, then per-transfer random stall
            if (hold_off > 0) begin
                hold_off    <= hold_off - 1;
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap     <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                out_gap     <= $urandom_range(0, 13);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle > MaxCycles) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cfg_write(input logic [bsc_pkg::CfgIdxW-1:0] idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bsc_pkg::CFG_CAL_TEMP:    cal_t  = val;
            bsc_pkg::CFG_CAL_PRESS_A: cal_pa = val;
            bsc_pkg::CFG_CAL_PRESS_B: cal_pb = val;
            bsc_pkg::CFG_CAL_PRESS_C: cal_pc = val;
            default: ;
        endcase
    endtask

    // wait until every sample is taken and every reading has come back
    task automatic drain();
        while (sample_q.size() > 0 || reading_q.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic bsc_pkg::t_in_item mk(input logic f, input logic [19:0] raw);
        bsc_pkg::t_in_item s;
        s.func = f;
        s.raw_sample = raw;
        return s;
    endfunction

    // realistic calibration around a typical sensor, with random spread
    task automatic cfg_typical();
        cfg_write(bsc_pkg::CFG_CAL_TEMP, {16'd50 + 16'($urandom_range(0, 40)),
                                 16'd26000 + 16'($urandom_range(0, 2000)),
                                 16'd27000 + 16'($urandom_range(0, 2000))});
        cfg_write(bsc_pkg::CFG_CAL_PRESS_A, {16'hD0B8 + 16'($urandom_range(0, 200)),
                                    16'hD5D0 + 16'($urandom_range(0, 400)),
                                    16'd36000 + 16'($urandom_range(0, 2000))});
        cfg_write(bsc_pkg::CFG_CAL_PRESS_B, {16'hFFF9, 16'h008C + 16'($urandom_range(0, 40)),
                                    16'd2800 + 16'($urandom_range(0, 400))});
        cfg_write(bsc_pkg::CFG_CAL_PRESS_C, {16'd6000, 16'hC000 + 16'($urandom_range(0, 8)),
                                    16'd15000});
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_out_stall = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        t_fine = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero calibration: pressure divisor is zero
        sample_q.push_back(mk(1'b1, 20'h80000));
        sample_q.push_back(mk(1'b0, 20'h00000));
        sample_q.push_back(mk(1'b1, 20'hFFFFF));
        drain();

        // extreme calibration words, every field at its edges
        cfg_write(bsc_pkg::CFG_CAL_TEMP, 48'hFFFF_FFFF_FFFF);
        cfg_write(bsc_pkg::CFG_CAL_PRESS_A, 48'h7FFF_7FFF_FFFF);
        cfg_write(bsc_pkg::CFG_CAL_PRESS_B, 48'h8000_8000_8000);
        cfg_write(bsc_pkg::CFG_CAL_PRESS_C, 48'h7FFF_8000_7FFF);
        sample_q.push_back(mk(1'b0, 20'hFFFFF));
        sample_q.push_back(mk(1'b1, 20'h00000));
        sample_q.push_back(mk(1'b1, 20'hFFFFF));
        sample_q.push_back(mk(1'b0, 20'h00000));
        sample_q.push_back(mk(1'b1, 20'h55555));
        drain();
        cfg_write(bsc_pkg::CFG_CAL_TEMP, 48'h8000_8000_0000);
        cfg_write(bsc_pkg::CFG_CAL_PRESS_A, 48'h8000_8000_0001);
        sample_q.push_back(mk(1'b0, 20'hAAAAA));
        sample_q.push_back(mk(1'b1, 20'hAAAAA));
        sample_q.push_back(mk(1'b0, 20'h12345));
        sample_q.push_back(mk(1'b1, 20'h00001));
        drain();

        // typical calibration, directed readings
        cfg_typical();
        sample_q.push_back(mk(1'b0, 20'd519888));
        sample_q.push_back(mk(1'b1, 20'd415148));
        sample_q.push_back(mk(1'b1, 20'h00000));
        sample_q.push_back(mk(1'b1, 20'hFFFFF));
        sample_q.push_back(mk(1'b0, 20'hFFFFF));
        sample_q.push_back(mk(1'b1, 20'd300000));
        drain();

        // random phases: mostly typical calibration, some fully random
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) begin
                cfg_write(bsc_pkg::CFG_CAL_TEMP, 48'({$urandom, $urandom}));
                cfg_write(bsc_pkg::CFG_CAL_PRESS_A, 48'({$urandom, $urandom}));
                cfg_write(bsc_pkg::CFG_CAL_PRESS_B, 48'({$urandom, $urandom}));
                cfg_write(bsc_pkg::CFG_CAL_PRESS_C, 48'({$urandom, $urandom}));
            end else begin
                cfg_typical();
            end
            // an index past the last register must be ignored
            cfg_write(8'd4 + 8'($urandom_range(0, 251)), 48'({$urandom, $urandom}));
            for (int k = 0; k < 178; k++) begin
                sample_q.push_back(mk(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                               : 20'd250000 + 20'($urandom_range(0, 400000))));
            end
            // receiver holds off long while the sender keeps offering
            if (ph == 1) begin
                repeat (20) @(posedge i_clk);
                hold_off <= 900;
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
design/bsc_pkg.sv
design/baro_sensor_compensation_top.sv
tb/baro_sensor_compensation_top_tb.sv
